/* sv/two_class_fifo_oldest_first_defines.svh */
// Assertion macros shared by the two-class FIFO RTL.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TCF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tcfof_pkg.sv */
// Types and constants for the two-class oldest-first FIFO.
package tcfof_pkg;

    localparam int TCF_DEPTH = 16;

    localparam logic [7:0] KIND_CLASS0 = 8'd99;
    localparam logic [7:0] KIND_CLASS1 = 8'd100;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ_ANY = 2'd1,
        OP_DEQ_C0  = 2'd2,
        OP_DEQ_C1  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BADKIND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef struct packed {
        op_t         operation;
        logic [15:0] tag;
        logic [7:0]  kind_code;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] out_tag;
        logic        out_kind;
    } rsp_t;

endpackage

/* sv/two_class_fifo_oldest_first.sv */
// Two-class FIFO of tags with oldest-first removal, top level.
//
// Requests arrive on req (valid/ready beat) and each produces exactly one
// response beat on rsp. An enqueue stores a tag into the class chosen by
// its kind byte; dequeues remove the head of one class, or the older head
// of the two classes by a modular arrival-stamp compare.
// Each class is a ring in its own synchronous memory of DEPTH entries
// holding the tag and its arrival stamp; heads and counts live in flops.
// Timing: an enqueue answers in the cycle after acceptance; a dequeue
// first reads both head entries from memory into registers, then picks
// and retires the head. Throughput is one enqueue per cycle while the
// receiver takes each response; no new request is taken while a dequeue
// reads its heads, since req_ready is low outside the idle state.
// Reset clears heads, counts, the arrival stamp and the response valid flag;
// the memories need no clearing since data from empty slots is never used.
// A stalled receiver holds the response register; a new request is taken
// only when idle, with the response register empty or draining now.
module two_class_fifo_oldest_first
    import tcfof_pkg::*;
#(
    parameter int DEPTH = TCF_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

`include "two_class_fifo_oldest_first_defines.svh"

    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int SW        = $clog2(2 * DEPTH);
    localparam int STAMP_MOD = 2 * DEPTH;
    localparam int EW        = SW + 16;

    localparam logic [CW:0]   DEPTH_C     = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX    = AW'(DEPTH - 1);
    localparam logic [SW-1:0] STAMP_LAST  = SW'(STAMP_MOD - 1);
    localparam logic [SW:0]   STAMP_MOD_W = (SW + 1)'(STAMP_MOD);
    localparam logic [SW:0]   DEPTH_S     = (SW + 1)'(DEPTH);

    // Ring storage: {stamp, tag} per slot
    logic [EW-1:0] mem0 [DEPTH];
    logic [EW-1:0] mem1 [DEPTH];
    logic [EW-1:0] rdata0_reg;
    logic [EW-1:0] rdata1_reg;

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [AW-1:0] head0_reg, head0_next;
    logic [AW-1:0] head1_reg, head1_next;
    logic [CW-1:0] count0_reg, count0_next;
    logic [CW-1:0] count1_reg, count1_next;
    logic [SW-1:0] stamp_reg, stamp_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          req_fire;
    logic          rd_en;
    logic          wr0_en, wr1_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [CW:0]   total;
    logic [CW:0]   pos_sum;
    logic [CW:0]   pos_wrap;
    logic [AW-1:0] head_sel;
    logic [CW-1:0] count_sel;
    logic [SW-1:0] s0, s1;
    logic [SW:0]   age_diff;
    logic          c0_older;
    logic [1:0]    pick;   // [1] some class chosen, [0] which class

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Occupancy and push slot for the addressed class
    assign total     = {1'b0, count0_reg} + {1'b0, count1_reg};
    assign head_sel  = (req.kind_code == KIND_CLASS0) ? head0_reg : head1_reg;
    assign count_sel = (req.kind_code == KIND_CLASS0) ? count0_reg : count1_reg;
    assign pos_sum   = (CW + 1)'(head_sel) + {1'b0, count_sel};
    assign pos_wrap  = (pos_sum >= DEPTH_C) ? (pos_sum - DEPTH_C) : pos_sum;

    // Modular age compare of the two head stamps
    assign s0       = rdata0_reg[EW-1:16];
    assign s1       = rdata1_reg[EW-1:16];
    assign age_diff = (s1 >= s0) ? ({1'b0, s1} - {1'b0, s0})
                                 : ({1'b0, s1} + STAMP_MOD_W - {1'b0, s0});
    assign c0_older = (age_diff < DEPTH_S);

    // Choose the class to pop for the pending dequeue
    always_comb
    begin
        pick = 2'b00;
        case (op_reg)
            OP_DEQ_C0:
            begin
                pick = {(count0_reg != '0), 1'b0};
            end
            OP_DEQ_C1:
            begin
                pick = {(count1_reg != '0), 1'b1};
            end
            OP_DEQ_ANY:
            begin
                if (count0_reg != '0 && count1_reg != '0)
                    pick = {1'b1, !c0_older};
                else if (count0_reg != '0)
                    pick = 2'b10;
                else if (count1_reg != '0)
                    pick = 2'b11;
                else
                    pick = 2'b00;
            end
            default:
            begin
                pick = 2'b00;
            end
        endcase
    end

    // Next state, pointer updates and response
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        head0_next     = head0_reg;
        head1_next     = head1_reg;
        count0_next    = count0_reg;
        count1_next    = count1_reg;
        stamp_next     = stamp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        wr0_en         = 1'b0;
        wr1_en         = 1'b0;
        wr_addr        = pos_wrap[AW-1:0];
        wr_data        = {stamp_reg, req.tag};

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.operation == OP_ENQ)
                    begin
                        rsp_valid_next   = 1'b1;
                        rsp_next.out_tag  = '0;
                        rsp_next.out_kind = 1'b0;
                        if (req.kind_code != KIND_CLASS0 && req.kind_code != KIND_CLASS1)
                            rsp_next.status = ST_BADKIND;
                        else if (total >= DEPTH_C)
                            rsp_next.status = ST_FULL;
                        else
                        begin
                            rsp_next.status = ST_OK;
                            if (req.kind_code == KIND_CLASS0)
                            begin
                                wr0_en      = 1'b1;
                                count0_next = count0_reg + 1'b1;
                            end
                            else
                            begin
                                wr1_en      = 1'b1;
                                count1_next = count1_reg + 1'b1;
                            end
                            stamp_next = (stamp_reg == STAMP_LAST) ? '0 : stamp_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        op_next    = req.operation;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
                if (!pick[1])
                begin
                    rsp_next.status   = ST_EMPTY;
                    rsp_next.out_tag  = '0;
                    rsp_next.out_kind = 1'b0;
                end
                else if (!pick[0])
                begin
                    rsp_next.status   = ST_OK;
                    rsp_next.out_tag  = rdata0_reg[15:0];
                    rsp_next.out_kind = 1'b0;
                    head0_next  = (head0_reg == LAST_IDX) ? '0 : head0_reg + 1'b1;
                    count0_next = count0_reg - 1'b1;
                end
                else
                begin
                    rsp_next.status   = ST_OK;
                    rsp_next.out_tag  = rdata1_reg[15:0];
                    rsp_next.out_kind = 1'b1;
                    head1_next  = (head1_reg == LAST_IDX) ? '0 : head1_reg + 1'b1;
                    count1_next = count1_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ENQ;
            head0_reg     <= '0;
            head1_reg     <= '0;
            count0_reg    <= '0;
            count1_reg    <= '0;
            stamp_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            head0_reg     <= head0_next;
            head1_reg     <= head1_next;
            count0_reg    <= count0_next;
            count1_reg    <= count1_next;
            stamp_reg     <= stamp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Class 0 ring memory
    always_ff @(posedge clk)
    begin
        if (wr0_en)
            mem0[wr_addr] <= wr_data;
        if (rd_en)
            rdata0_reg <= mem0[head0_reg];
    end

    // Class 1 ring memory
    always_ff @(posedge clk)
    begin
        if (wr1_en)
            mem1[wr_addr] <= wr_data;
        if (rd_en)
            rdata1_reg <= mem1[head1_reg];
    end

    // Checks
    `TCF_ASSERT_SAME(a_total_cap, 1'b1, total <= DEPTH_C, "occupancy exceeds DEPTH")
    `TCF_ASSERT_NEXT(a_deq_reads, req_fire && req.operation != OP_ENQ, state_reg == S_READ, "dequeue did not enter head read")
    `TCF_ASSERT_SAME(a_read_slot_free, state_reg == S_READ, !rsp_valid_reg, "response register busy during head read")

endmodule
